// ===== rtl/hcbp_pkg.sv =====
// Shared types, constants and helpers for the prefix-code bit packer.
// Used by huffman_code_bit_packer, hcbp_code_table and hcbp_out_fifo.
package hcbp_pkg;

	localparam int WORD_BITS   = 32;
	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LEN_W       = $clog2(WORD_BITS + 1);
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_AW      = $clog2(OUT_DEPTH);
	localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	localparam logic [7:0] END_SYMBOL_RESET = 8'd213;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [LEN_W-1:0]     len_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  symbol;
		logic [31:0] code_bits;
		logic [5:0]  code_length;
	} hcbp_in_t;

	typedef struct packed {
		logic [31:0] packed_word;
		logic        last;
	} hcbp_out_t;

	// Up to two result words produced by one item in a single cycle.
	typedef struct packed {
		logic [1:0] n;
		hcbp_out_t  w0;
		hcbp_out_t  w1;
	} hcbp_push_t;

	// Mask of the low n bits of a word; n equal to WORD_BITS gives all ones.
	function automatic word_t word_mask(input len_t n);
		return ~({WORD_BITS{1'b1}} << n);
	endfunction

endpackage

// ===== rtl/hcbp_code_table.sv =====
// Code and length table of the bit packer, one write and one registered read port.
// Depends on hcbp_pkg for the table geometry and the word and length types.
module hcbp_code_table
	import hcbp_pkg::*;
(
	input  logic                clk,
	input  logic                wr_en,
	input  logic [TABLE_AW-1:0] wr_addr,
	input  word_t               wr_code,
	input  len_t                wr_len,
	input  logic                rd_en,
	input  logic [TABLE_AW-1:0] rd_addr,
	output word_t               rd_code,
	output len_t                rd_len
);

	typedef struct packed {
		len_t  len;
		word_t code;
	} entry_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{len: wr_len, code: wr_code};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_q.code;
	assign rd_len  = rd_q.len;

endmodule

// ===== rtl/hcbp_out_fifo.sv =====
// Small result queue that takes up to two words a cycle and hands out one.
// Depends on hcbp_pkg for the result and push bundle types.
module hcbp_out_fifo
	import hcbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  hcbp_push_t push,
	output logic       room_ok,
	output logic       word_valid,
	input  logic       word_ready,
	output hcbp_out_t  word_data
);

	hcbp_out_t         entry_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q;
	logic [OUT_AW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] count_q;
	logic              pop;

	assign word_valid = (count_q != '0);
	assign word_data  = entry_q[rd_ptr_q];
	assign pop        = word_valid && word_ready;
	// Space for a full two-word push, judged before this cycle's pop.
	assign room_ok    = (count_q <= OUT_CW'(OUT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_ptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			entry_q[OUT_AW'(wr_ptr_q + 1'b1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= OUT_AW'(wr_ptr_q + OUT_AW'(push.n));
			if (pop) begin
				rd_ptr_q <= OUT_AW'(rd_ptr_q + 1'b1);
			end
			count_q <= OUT_CW'(count_q + OUT_CW'(push.n) - OUT_CW'(pop));
		end
	end

endmodule

// ===== rtl/huffman_code_bit_packer.sv =====
// Prefix-code bit packer: the table read register and the result queue lie between
// an input transaction and word_valid. One item per cycle while the queue has room;
// a finish item can emit two words, drained one word per cycle while word_ready is
// high through a four-entry queue. The table read and bit buffer update pace items.
// Reset clears the bit buffer, the fill count and the queue; end_symbol resets to 213.
// The code table has no reset and must be loaded before use.
module huffman_code_bit_packer
	import hcbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sym_valid,
	output logic       sym_ready,
	input  hcbp_in_t   sym_data,
	output logic       word_valid,
	input  logic       word_ready,
	output hcbp_out_t  word_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0] end_symbol_q;
	logic       sym_acc;
	logic [7:0] rd_symbol;
	logic       rd_idx_ok;
	logic       wr_idx_ok;
	len_t       load_len;
	word_t      load_code;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic       idx_ok_s1;
	word_t      tbl_code;
	len_t       tbl_len;

	word_t      buf_q;
	len_t       fill_q;
	logic       s1_adv;
	logic       room_ok;

	word_t      buf0, buf1, buf_next, spill_word, final_word;
	len_t       fill0, fill1, fill_next, room, rest, app_len;
	word_t      app_code;
	logic       lazy, spill;
	hcbp_push_t push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_symbol_q <= END_SYMBOL_RESET;
		end else if (cfg_valid) begin
			end_symbol_q <= cfg_data;
		end
	end

	// Input side: the table is written or read at the transaction edge.
	assign sym_ready = !valid_s1 || s1_adv;
	assign sym_acc   = sym_valid && sym_ready;
	assign rd_symbol = (sym_data.func == FUNC_FINISH) ? end_symbol_q : sym_data.symbol;
	assign rd_idx_ok = ({1'b0, rd_symbol} < 9'(TABLE_DEPTH));
	assign wr_idx_ok = ({1'b0, sym_data.symbol} < 9'(TABLE_DEPTH));
	assign load_len  = (8'(sym_data.code_length) > 8'(WORD_BITS)) ?
		LEN_W'(WORD_BITS) : LEN_W'(sym_data.code_length);
	assign load_code = word_t'(sym_data.code_bits) & word_mask(load_len);

	hcbp_code_table u_table (
		.clk     (clk),
		.wr_en   (sym_acc && sym_data.func == FUNC_LOAD && wr_idx_ok),
		.wr_addr (sym_data.symbol[TABLE_AW-1:0]),
		.wr_code (load_code),
		.wr_len  (load_len),
		.rd_en   (sym_acc),
		.rd_addr (rd_symbol[TABLE_AW-1:0]),
		.rd_code (tbl_code),
		.rd_len  (tbl_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym_ready) begin
			valid_s1 <= sym_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_acc) begin
			func_s1   <= sym_data.func;
			idx_ok_s1 <= rd_idx_ok;
		end
	end

	assign s1_adv = valid_s1 && room_ok;

	// Append path: optional lazy emit of a full buffer, then the code is shifted in.
	always_comb begin
		lazy       = 1'b0;
		buf0       = buf_q;
		fill0      = fill_q;
		spill      = 1'b0;
		spill_word = '0;
		rest       = '0;
		if (func_s1 == FUNC_ENCODE && fill_q == LEN_W'(WORD_BITS)) begin
			lazy  = 1'b1;
			buf0  = '0;
			fill0 = '0;
		end
		app_code = idx_ok_s1 ? tbl_code : '0;
		app_len  = idx_ok_s1 ? tbl_len : '0;
		room     = LEN_W'(LEN_W'(WORD_BITS) - fill0);
		if (room >= app_len) begin
			buf1  = (buf0 << app_len) | app_code;
			fill1 = LEN_W'(fill0 + app_len);
		end else begin
			spill      = 1'b1;
			rest       = LEN_W'(app_len - room);
			spill_word = (buf0 << room) | (app_code >> rest);
			buf1       = app_code & word_mask(rest);
			fill1      = rest;
		end
		final_word = buf1 << LEN_W'(LEN_W'(WORD_BITS) - fill1);
	end

	always_comb begin
		push      = '0;
		buf_next  = buf_q;
		fill_next = fill_q;
		if (s1_adv) begin
			case (func_s1)
				FUNC_ENCODE: begin
					buf_next  = buf1;
					fill_next = fill1;
					if (lazy) begin
						push.n  = 2'd1;
						push.w0 = '{packed_word: 32'(buf_q), last: 1'b0};
					end else if (spill) begin
						push.n  = 2'd1;
						push.w0 = '{packed_word: 32'(spill_word), last: 1'b0};
					end
				end
				FUNC_FINISH: begin
					buf_next  = '0;
					fill_next = '0;
					if (spill) begin
						push.n  = 2'd2;
						push.w0 = '{packed_word: 32'(spill_word), last: 1'b0};
						push.w1 = '{packed_word: 32'(final_word), last: 1'b1};
					end else begin
						push.n  = 2'd1;
						push.w0 = '{packed_word: 32'(final_word), last: 1'b1};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			fill_q <= '0;
		end else begin
			buf_q  <= buf_next;
			fill_q <= fill_next;
		end
	end

	hcbp_out_fifo u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room_ok    (room_ok),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_data  (word_data)
	);

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(WORD_BITS))
		else $error("bit buffer fill count exceeds the word width");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && func_s1 == FUNC_FINISH |=> fill_q == '0 && buf_q == '0)
		else $error("finish did not empty the bit buffer");

	a_encode_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && func_s1 == FUNC_ENCODE |-> push.n <= 2'd1)
		else $error("encode produced more than one word");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.w1.last && !push.w0.last)
		else $error("two-word push without the last flag on the second word only");

	a_no_push_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!room_ok |-> push.n == 2'd0)
		else $error("result pushed while the queue lacks room");

endmodule

// ===== tb/sv/huffman_code_bit_packer_tb.sv =====
// Self-checking testbench for the prefix-code bit packer (huffman_code_bit_packer).
// It needs hcbp_pkg for the payload types and func codes. A built-in predictor
// checks every packed word under random backpressure and several end-symbol settings.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// One row of the directed table. When pinned is set, the words given in the row
	// are the expected results; otherwise the predictor supplies them.
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  symbol;
		logic [31:0] code;
		logic [5:0]  code_len;
		logic        pinned;
		logic [1:0]  cnt;
		logic [31:0] w0;
		logic        l0;
		logic [31:0] w1;
		logic        l1;
	} dir_row_t;

	typedef struct {
		bit         pinned;
		int         cnt;
		hcbp_out_t  w0;
		hcbp_out_t  w1;
	} word_set_t;

	localparam int DIR_N = 26;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{FUNC_LOAD,   8'd213, 32'h0000_0005, 6'd3,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd32, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd255, 32'hDEAD_BEEF, 6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd1,   32'hFFFF_FFFF, 6'd63, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd2,   32'hFFFF_FFFF, 6'd4,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_UNUSED, 8'hAA,  32'h1234_5678, 6'd5,  1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b1, 2'd1, 32'hA000_0000, 1'b1,
			32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd0,   32'h0,         6'd0,  1'b1, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd1,   32'h0,         6'd0,  1'b1, 2'd1, 32'hFFFF_FFFF, 1'b0,
			32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b1, 2'd2, 32'hFFFF_FFFF, 1'b0,
			32'hA000_0000, 1'b1},
		'{FUNC_ENCODE, 8'd2,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b1, 2'd1, 32'hFA00_0000, 1'b1,
			32'h0, 1'b0},
		'{FUNC_LOAD,   8'd213, 32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b1, 2'd1, 32'h0000_0000, 1'b1,
			32'h0, 1'b0},
		'{FUNC_LOAD,   8'd3,   32'h0001_ABCD, 6'd17, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd3,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd3,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd2,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd213, 32'h0000_002A, 6'd7,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_LOAD,   8'd4,   32'h8000_0001, 6'd33, 1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd4,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd3,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_ENCODE, 8'd0,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{FUNC_FINISH, 8'd0,   32'h0,         6'd0,  1'b0, 2'd0, 32'h0, 1'b0, 32'h0, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       sym_valid;
	logic       sym_ready;
	hcbp_in_t   sym_data;
	logic       word_valid;
	logic       word_ready;
	hcbp_out_t  word_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	huffman_code_bit_packer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.sym_data   (sym_data),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_data  (word_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: code table, bit accumulator and the end symbol.
	logic [31:0] sym_code [256];
	logic [5:0]  sym_len  [256];
	logic [31:0] acc_word = '0;
	int unsigned acc_fill = 0;
	logic [7:0]  end_sym  = END_SYMBOL_RESET;

	hcbp_out_t   pending_words [$];
	word_set_t   pinned_words [$];
	bit          loaded [256];
	logic [7:0]  loaded_syms [$];

	int gap_pct = 0;
	int fail_count = 0;
	int items_sent = 0;
	int words_seen = 0;
	int cfg_writes = 0;
	int finishes_sent = 0;

	task automatic add_word(inout word_set_t ws, input logic [31:0] w, input logic l);
		if (ws.cnt == 0)
			ws.w0 = '{packed_word: w, last: l};
		else
			ws.w1 = '{packed_word: w, last: l};
		ws.cnt++;
	endtask

	// Appends a code MSB first; a code that crosses the word boundary completes a word.
	task automatic append_code(inout word_set_t ws, input logic [31:0] code,
			input int unsigned len);
		int unsigned room;
		int unsigned rest;
		logic [63:0] wide;
		room = 32 - acc_fill;
		if (room >= len) begin
			wide = {32'd0, acc_word} << len;
			acc_word = wide[31:0] | code;
			acc_fill += len;
		end else begin
			rest = len - room;
			wide = {32'd0, acc_word} << room;
			acc_word = wide[31:0] | (code >> rest);
			add_word(ws, acc_word, 1'b0);
			wide = {32'd0, code} & ((64'd1 << rest) - 64'd1);
			acc_word = wide[31:0];
			acc_fill = rest;
		end
	endtask

	task automatic pack_symbol_item(input hcbp_in_t it, output word_set_t ws);
		int unsigned len;
		logic [63:0] wide;
		ws.pinned = 1'b0;
		ws.cnt = 0;
		ws.w0 = '0;
		ws.w1 = '0;
		case (it.func)
			FUNC_LOAD: begin
				len = (it.code_length > 6'd32) ? 32 : it.code_length;
				wide = {32'd0, it.code_bits} & ((64'd1 << len) - 64'd1);
				sym_len[it.symbol] = len[5:0];
				sym_code[it.symbol] = wide[31:0];
			end
			FUNC_ENCODE: begin
				// A full accumulator is only flushed when the next symbol arrives.
				if (acc_fill >= 32) begin
					add_word(ws, acc_word, 1'b0);
					acc_word = '0;
					acc_fill = 0;
				end
				append_code(ws, sym_code[it.symbol], sym_len[it.symbol]);
			end
			FUNC_FINISH: begin
				append_code(ws, sym_code[end_sym], sym_len[end_sym]);
				wide = {32'd0, acc_word} << (32 - acc_fill);
				add_word(ws, wide[31:0], 1'b1);
				acc_word = '0;
				acc_fill = 0;
			end
			default: ;
		endcase
	endtask

	task automatic log_mismatch(input string what, input hcbp_out_t want, input hcbp_out_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch (%s) at %0t: expected word %h last %b, got word %h last %b",
				what, $realtime, want.packed_word, want.last, got.packed_word, got.last);
	endtask

	// Prediction on every accepted input transaction, checking on every output one.
	always @(posedge clk) begin
		word_set_t predicted;
		word_set_t forced;
		hcbp_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				end_sym = cfg_data;
			if (sym_valid && sym_ready) begin
				pack_symbol_item(sym_data, predicted);
				forced = pinned_words.pop_front();
				if (forced.pinned)
					predicted = forced;
				if (predicted.cnt >= 1)
					pending_words.push_back(predicted.w0);
				if (predicted.cnt == 2)
					pending_words.push_back(predicted.w1);
			end
			if (word_valid && word_ready) begin
				words_seen++;
				if (pending_words.size() == 0) begin
					log_mismatch("no word expected", '0, word_data);
				end else begin
					want = pending_words.pop_front();
					if (word_data.packed_word !== want.packed_word ||
							word_data.last !== want.last)
						log_mismatch("wrong field", want, word_data);
				end
			end
		end
	end

	// Output side: word_ready is dropped in random stall bursts.
	initial begin
		word_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < gap_pct) begin
				word_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			word_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_item(input hcbp_in_t it, input word_set_t pin);
		if ($urandom_range(0, 99) < gap_pct) begin
			sym_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pinned_words.push_back(pin);
		if (it.func == FUNC_LOAD && !loaded[it.symbol]) begin
			loaded[it.symbol] = 1'b1;
			loaded_syms.push_back(it.symbol);
		end
		if (it.func == FUNC_FINISH)
			finishes_sent++;
		sym_valid <= 1'b1;
		sym_data <= it;
		do
			@(posedge clk);
		while (!sym_ready);
		items_sent++;
	endtask

	// Drops valid, waits for every expected word, then lets in-flight loads retire.
	task automatic settle();
		sym_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic hcbp_in_t make_load(input logic [7:0] sym);
		hcbp_in_t it;
		int unsigned pick;
		it.func = FUNC_LOAD;
		it.symbol = sym;
		it.code_bits = $urandom;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			it.code_length = 6'd0;
		else if (pick <= 2)
			it.code_length = 6'($urandom_range(33, 63));
		else if (pick <= 5)
			it.code_length = 6'($urandom_range(17, 32));
		else
			it.code_length = 6'($urandom_range(1, 16));
		return it;
	endfunction

	// Mostly encodes of loaded symbols, with loads, finishes and unused func as noise.
	function automatic hcbp_in_t make_random_item();
		hcbp_in_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
		it.code_bits = $urandom;
		it.code_length = 6'($urandom_range(0, 63));
		if (r < 14)
			it = make_load(8'($urandom_range(0, 255)));
		else if (r < 88)
			it.func = FUNC_ENCODE;
		else if (r < 95)
			it.func = FUNC_FINISH;
		else begin
			it.func = FUNC_UNUSED;
			it.symbol = 8'($urandom_range(0, 255));
		end
		return it;
	endfunction

	task automatic run_phase(input int n_items, input int pct, input bit set_end,
			input logic [7:0] end_val);
		word_set_t no_pin;
		int k;
		no_pin = '{pinned: 1'b0, cnt: 0, w0: '0, w1: '0};
		settle();
		gap_pct = pct;
		if (set_end) begin
			cfg_valid <= 1'b1;
			cfg_data <= end_val;
			do
				@(posedge clk);
			while (!cfg_ready);
			cfg_valid <= 1'b0;
			cfg_writes++;
			// The new end symbol's entry must hold a code before any finish reads it.
			send_item(make_load(end_val), no_pin);
		end
		for (k = 0; k < n_items; k++)
			send_item(make_random_item(), no_pin);
	endtask

	initial begin
		word_set_t pin;
		hcbp_in_t it;
		int k;
		arst_n <= 1'b0;
		sym_valid <= 1'b0;
		sym_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		gap_pct = 15;
		for (k = 0; k < DIR_N; k++) begin
			it.func = DIR_ROWS[k].func;
			it.symbol = DIR_ROWS[k].symbol;
			it.code_bits = DIR_ROWS[k].code;
			it.code_length = DIR_ROWS[k].code_len;
			pin.pinned = DIR_ROWS[k].pinned;
			pin.cnt = DIR_ROWS[k].cnt;
			pin.w0 = '{packed_word: DIR_ROWS[k].w0, last: DIR_ROWS[k].l0};
			pin.w1 = '{packed_word: DIR_ROWS[k].w1, last: DIR_ROWS[k].l1};
			send_item(it, pin);
		end

		run_phase(230, 20, 1'b1, 8'd0);
		run_phase(230, 40, 1'b1, 8'd255);
		run_phase(230, 0, 1'b1, 8'($urandom_range(0, 255)));
		run_phase(230, 25, 1'b1, 8'($urandom_range(0, 255)));
		run_phase(230, 10, 1'b1, END_SYMBOL_RESET);
		run_phase(200, 0, 1'b0, 8'd0);
		settle();

		$display("covered %0d input transactions (%0d finishes), %0d packed words checked,",
			items_sent, finishes_sent, words_seen);
		$display("%0d end-symbol writes including both extremes; %0d failures",
			cfg_writes, fail_count);
		if (fail_count == 0)
			$display("huffman_code_bit_packer regression: pass");
		else
			$display("huffman_code_bit_packer regression: fail");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout waiting on the packer");
		$display("huffman_code_bit_packer regression: fail");
		$finish;
	end

endmodule

// ===== huffman_code_bit_packer.f =====
rtl/hcbp_pkg.sv
rtl/hcbp_code_table.sv
rtl/hcbp_out_fifo.sv
rtl/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_tb.sv
